FILE: design/spmq_pkg.sv
// ----------------------------------------------------------------------------
// spmq_pkg
// Shared types and constants of the strict priority message queue.
// ----------------------------------------------------------------------------
package spmq_pkg;

  localparam int NUM_LEVELS = 4;
  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;

  localparam int OP_W      = 1;
  localparam int PRI_W     = 3;
  localparam int PAYLOAD_W = 32;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 7;

  localparam int LVL_W   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W   = $clog2(DEPTH + 1);
  localparam int CMP_W   = (OCC_W > COUNT_W) ? OCC_W : COUNT_W;
  localparam int ENTRIES = NUM_LEVELS * DEPTH;
  localparam int ADDR_W  = $clog2(ENTRIES);

  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_W = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  localparam logic [OP_W-1:0] OP_ENQ = 1'b0;
  localparam logic [OP_W-1:0] OP_DEQ = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPRI = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [ADDR_W-1:0]     addr;
    logic [DATA_WIDTH-1:0] data;
    status_t               status;
    logic [PRI_W-1:0]      level;
    logic [COUNT_W-1:0]    count;
  } cmd_t;

endpackage

FILE: design/spmq_front.sv
// ----------------------------------------------------------------------------
// spmq_front
// Accepts transactions, checks priority and capacity, keeps per-level ring
// pointers and counts, and issues one storage command per transaction.
// ----------------------------------------------------------------------------
module spmq_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [spmq_pkg::COUNT_W-1:0]     cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [spmq_pkg::OP_W-1:0]        in_operation,
  input  logic [spmq_pkg::PRI_W-1:0]       in_priority_req,
  input  logic [spmq_pkg::PAYLOAD_W-1:0]   in_payload,
  input  logic                             cq_full,
  output logic                             cq_push,
  output spmq_pkg::cmd_t                   cq_cmd
);

  logic [spmq_pkg::COUNT_W-1:0] cap_r;
  logic [spmq_pkg::OCC_W-1:0]   occ_r, occ_nxt;
  logic [spmq_pkg::IDX_W-1:0]   head_r [spmq_pkg::NUM_LEVELS];
  logic [spmq_pkg::IDX_W-1:0]   tail_r [spmq_pkg::NUM_LEVELS];
  logic [spmq_pkg::OCC_W-1:0]   lcnt_r [spmq_pkg::NUM_LEVELS];
  logic [spmq_pkg::IDX_W-1:0]   head_nxt [spmq_pkg::NUM_LEVELS];
  logic [spmq_pkg::IDX_W-1:0]   tail_nxt [spmq_pkg::NUM_LEVELS];
  logic [spmq_pkg::OCC_W-1:0]   lcnt_nxt [spmq_pkg::NUM_LEVELS];

  logic                         accept;
  logic                         bad_pri;
  logic                         is_full;
  logic                         found;
  logic [spmq_pkg::LVL_W-1:0]   sel;
  logic [spmq_pkg::LVL_W-1:0]   pri_lvl;
  logic [spmq_pkg::IDX_W-1:0]   tail_sel;
  logic [spmq_pkg::IDX_W-1:0]   head_sel;
  logic                         enq_ok;
  logic                         deq_ok;

  function automatic logic [spmq_pkg::IDX_W-1:0] ring_next(
    input logic [spmq_pkg::IDX_W-1:0] p
  );
    if (p == spmq_pkg::IDX_W'(spmq_pkg::DEPTH - 1)) begin
      return '0;
    end
    return p + spmq_pkg::IDX_W'(1);
  endfunction

  assign in_stall = cq_full;
  assign accept   = in_valid && !cq_full;
  assign pri_lvl  = spmq_pkg::LVL_W'(in_priority_req);

  always_comb begin
    bad_pri = {1'b0, in_priority_req} >= (spmq_pkg::PRI_W + 1)'(spmq_pkg::NUM_LEVELS);
    is_full = (spmq_pkg::CMP_W'(occ_r) >= spmq_pkg::CMP_W'(spmq_pkg::DEPTH)) ||
              ((cap_r != '0) && (spmq_pkg::CMP_W'(occ_r) >= spmq_pkg::CMP_W'(cap_r)));

    found    = 1'b0;
    sel      = '0;
    tail_sel = '0;
    head_sel = '0;
    for (int lv = 0; lv < spmq_pkg::NUM_LEVELS; lv++) begin
      if (!found && (lcnt_r[lv] != '0)) begin
        found    = 1'b1;
        sel      = spmq_pkg::LVL_W'(lv);
        head_sel = head_r[lv];
      end
      if (pri_lvl == spmq_pkg::LVL_W'(lv)) begin
        tail_sel = tail_r[lv];
      end
    end

    enq_ok = accept && (in_operation == spmq_pkg::OP_ENQ) && !bad_pri && !is_full;
    deq_ok = accept && (in_operation == spmq_pkg::OP_DEQ) && found;

    for (int lv = 0; lv < spmq_pkg::NUM_LEVELS; lv++) begin
      head_nxt[lv] = head_r[lv];
      tail_nxt[lv] = tail_r[lv];
      lcnt_nxt[lv] = lcnt_r[lv];
      if (enq_ok && (pri_lvl == spmq_pkg::LVL_W'(lv))) begin
        tail_nxt[lv] = ring_next(tail_r[lv]);
        lcnt_nxt[lv] = lcnt_r[lv] + spmq_pkg::OCC_W'(1);
      end
      if (deq_ok && (sel == spmq_pkg::LVL_W'(lv))) begin
        head_nxt[lv] = ring_next(head_r[lv]);
        lcnt_nxt[lv] = lcnt_r[lv] - spmq_pkg::OCC_W'(1);
      end
    end

    occ_nxt = occ_r;
    if (enq_ok) begin
      occ_nxt = occ_r + spmq_pkg::OCC_W'(1);
    end else if (deq_ok) begin
      occ_nxt = occ_r - spmq_pkg::OCC_W'(1);
    end

    cq_cmd        = '0;
    cq_cmd.kind   = spmq_pkg::CMD_NONE;
    cq_cmd.data   = spmq_pkg::DATA_WIDTH'(in_payload);
    cq_cmd.count  = spmq_pkg::COUNT_W'(occ_nxt);
    cq_cmd.status = spmq_pkg::ST_OK;
    if (in_operation == spmq_pkg::OP_ENQ) begin
      cq_cmd.addr = spmq_pkg::ADDR_W'(int'(pri_lvl) * spmq_pkg::DEPTH) +
                    spmq_pkg::ADDR_W'(tail_sel);
      if (bad_pri) begin
        cq_cmd.status = spmq_pkg::ST_BADPRI;
      end else if (is_full) begin
        cq_cmd.status = spmq_pkg::ST_FULL;
      end else begin
        cq_cmd.kind = spmq_pkg::CMD_WRITE;
      end
    end else begin
      cq_cmd.addr = spmq_pkg::ADDR_W'(int'(sel) * spmq_pkg::DEPTH) +
                    spmq_pkg::ADDR_W'(head_sel);
      if (found) begin
        cq_cmd.kind  = spmq_pkg::CMD_READ;
        cq_cmd.level = spmq_pkg::PRI_W'(sel);
      end else begin
        cq_cmd.status = spmq_pkg::ST_EMPTY;
      end
    end
  end

  assign cq_push = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= '0;
      occ_r <= '0;
      for (int lv = 0; lv < spmq_pkg::NUM_LEVELS; lv++) begin
        head_r[lv] <= '0;
        tail_r[lv] <= '0;
        lcnt_r[lv] <= '0;
      end
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
      occ_r <= occ_nxt;
      for (int lv = 0; lv < spmq_pkg::NUM_LEVELS; lv++) begin
        head_r[lv] <= head_nxt[lv];
        tail_r[lv] <= tail_nxt[lv];
        lcnt_r[lv] <= lcnt_nxt[lv];
      end
    end
  end

endmodule

FILE: design/spmq_cmdq.sv
// ----------------------------------------------------------------------------
// spmq_cmdq
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module spmq_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  spmq_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output spmq_pkg::cmd_t pop_cmd
);

  spmq_pkg::cmd_t                 slot_r [spmq_pkg::CQ_DEPTH];
  logic [spmq_pkg::CQ_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [spmq_pkg::CQ_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [spmq_pkg::CQ_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                           do_push;
  logic                           do_pop;

  assign full      = (cnt_r == spmq_pkg::CQ_CNT_W'(spmq_pkg::CQ_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_cmd   = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == spmq_pkg::CQ_PTR_W'(spmq_pkg::CQ_DEPTH - 1)) ?
                   '0 : wr_ptr_r + spmq_pkg::CQ_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == spmq_pkg::CQ_PTR_W'(spmq_pkg::CQ_DEPTH - 1)) ?
                   '0 : rd_ptr_r + spmq_pkg::CQ_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + spmq_pkg::CQ_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - spmq_pkg::CQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: design/spmq_back.sv
// ----------------------------------------------------------------------------
// spmq_back
// Carries out storage commands against the entry memory and drives the
// result channel through a registered output stage.
// ----------------------------------------------------------------------------
module spmq_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cq_valid,
  input  spmq_pkg::cmd_t                    cq_cmd,
  output logic                              cq_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [spmq_pkg::STATUS_W-1:0]     out_status,
  output logic [spmq_pkg::PAYLOAD_W-1:0]    out_payload,
  output logic [spmq_pkg::PRI_W-1:0]        out_priority,
  output logic [spmq_pkg::COUNT_W-1:0]      out_total_count
);

  logic [spmq_pkg::DATA_WIDTH-1:0] mem [spmq_pkg::ENTRIES];
  logic [spmq_pkg::DATA_WIDTH-1:0] rd_data_r;

  logic                            a_valid_r;
  logic                            a_read_r;
  spmq_pkg::status_t               a_status_r;
  logic [spmq_pkg::PRI_W-1:0]      a_level_r;
  logic [spmq_pkg::COUNT_W-1:0]    a_count_r;

  logic                            o_valid_r;
  spmq_pkg::status_t               o_status_r;
  logic [spmq_pkg::PAYLOAD_W-1:0]  o_payload_r;
  logic [spmq_pkg::PRI_W-1:0]      o_level_r;
  logic [spmq_pkg::COUNT_W-1:0]    o_count_r;

  logic                            o_adv;
  logic                            a_adv;

  assign o_adv  = !o_valid_r || !out_stall;
  assign a_adv  = !a_valid_r || o_adv;
  assign cq_pop = cq_valid && a_adv;

  always_ff @(posedge clk) begin
    if (cq_pop && (cq_cmd.kind == spmq_pkg::CMD_WRITE)) begin
      mem[cq_cmd.addr] <= cq_cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (cq_pop) begin
      rd_data_r  <= mem[cq_cmd.addr];
      a_read_r   <= (cq_cmd.kind == spmq_pkg::CMD_READ);
      a_status_r <= cq_cmd.status;
      a_level_r  <= cq_cmd.level;
      a_count_r  <= cq_cmd.count;
    end
    if (a_valid_r && o_adv) begin
      o_status_r  <= a_status_r;
      o_payload_r <= a_read_r ? spmq_pkg::PAYLOAD_W'(rd_data_r) : '0;
      o_level_r   <= a_level_r;
      o_count_r   <= a_count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (a_adv) begin
        a_valid_r <= cq_pop;
      end
      if (o_adv) begin
        o_valid_r <= a_valid_r;
      end
    end
  end

  assign out_valid       = o_valid_r;
  assign out_status      = o_status_r;
  assign out_payload     = o_payload_r;
  assign out_priority    = o_level_r;
  assign out_total_count = o_count_r;

endmodule

FILE: design/strict_priority_message_queue.sv
// ----------------------------------------------------------------------------
// strict_priority_message_queue
// Path: an accepted transaction is held in the command queue, goes to the read
//   stage and from there to the output register; out_stall can hold it.
// Throughput: one transaction per cycle unless stalled; one mem access each.
// Reset: pointers, counts, capacity limit and valid flags clear; entry memory
//   is left as is and its data is only used after being written.
// ----------------------------------------------------------------------------
module strict_priority_message_queue (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [spmq_pkg::COUNT_W-1:0]     cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [spmq_pkg::OP_W-1:0]        in_operation,
  input  logic [spmq_pkg::PRI_W-1:0]       in_priority_req,
  input  logic [spmq_pkg::PAYLOAD_W-1:0]   in_payload,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [spmq_pkg::STATUS_W-1:0]    out_status,
  output logic [spmq_pkg::PAYLOAD_W-1:0]   out_payload,
  output logic [spmq_pkg::PRI_W-1:0]       out_priority,
  output logic [spmq_pkg::COUNT_W-1:0]     out_total_count
);

  logic           cq_full;
  logic           cq_push;
  spmq_pkg::cmd_t cq_push_cmd;
  logic           cq_pop;
  logic           cq_valid;
  spmq_pkg::cmd_t cq_pop_cmd;

  spmq_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_priority_req (in_priority_req),
    .in_payload      (in_payload),
    .cq_full         (cq_full),
    .cq_push         (cq_push),
    .cq_cmd          (cq_push_cmd)
  );

  spmq_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cq_push),
    .push_cmd  (cq_push_cmd),
    .full      (cq_full),
    .pop       (cq_pop),
    .pop_valid (cq_valid),
    .pop_cmd   (cq_pop_cmd)
  );

  spmq_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cq_valid        (cq_valid),
    .cq_cmd          (cq_pop_cmd),
    .cq_pop          (cq_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_payload     (out_payload),
    .out_priority    (out_priority),
    .out_total_count (out_total_count)
  );

endmodule
